// File: src/c2kw_pkg.sv
// shared types and constants for the 2d convolution window block
// no dependencies; imported by the interfaces and every module but c2kw_ram
package c2kw_pkg;

    localparam int DEF_KERNEL_SIZE = 3;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_COL_W       = $clog2(DEF_MAX_WIDTH);

    // field widths
    localparam int PIX_W  = 8;
    localparam int FW_W   = 11;
    localparam int ROW_W  = 16;
    localparam int CIDX_W = 6;
    localparam int COEF_W = 16;
    localparam int SUM_W  = 30;
    localparam int PROD_W = PIX_W + 1 + COEF_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = FW_W'(640);
    localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = ROW_W'(480);

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_COEFF = 1'b1
    } op_t;

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              emit;
        logic              last;
        logic [ROW_W-1:0]  row;
    } tag_t;

endpackage

// File: src/c2kw_if.sv
// request and result channel interfaces for the convolution window block
// depends on c2kw_pkg
interface c2kw_in_if
    import c2kw_pkg::*;
;
    logic                      valid;
    logic                      ready;
    op_t                       operation;
    logic [PIX_W-1:0]          pixel;
    logic [CIDX_W-1:0]         coeff_index;
    logic signed [COEF_W-1:0]  coeff_value;

    modport source (output valid, operation, pixel, coeff_index, coeff_value, input ready);
    modport sink   (input valid, operation, pixel, coeff_index, coeff_value, output ready);
endinterface

interface c2kw_out_if
    import c2kw_pkg::*;
#(
    parameter int COL_W = DEF_COL_W
);
    logic                      valid;
    logic                      ready;
    logic signed [SUM_W-1:0]   conv_sum;
    logic [ROW_W-1:0]          out_row;
    logic [COL_W-1:0]          out_col;
    logic                      last_of_frame;

    modport source (output valid, conv_sum, out_row, out_col, last_of_frame, input ready);
    modport sink   (input valid, conv_sum, out_row, out_col, last_of_frame, output ready);
endinterface

// File: src/c2kw_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module c2kw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/c2kw_line_buf.sv
// line store ram and the k by k window shift registers
// depends on c2kw_pkg and c2kw_ram
module c2kw_line_buf
    import c2kw_pkg::*;
#(
    parameter int KERNEL_SIZE = DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int KK         = KERNEL_SIZE * KERNEL_SIZE,
    localparam int LB_W       = PIX_W * (KERNEL_SIZE - 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [COL_W-1:0]          rd_addr,
    input  logic                      shift_en,
    input  logic [COL_W-1:0]          wr_addr,
    input  logic [PIX_W-1:0]          px,
    output logic [KK-1:0][PIX_W-1:0]  window
);

    logic [LB_W-1:0]                rd_data;
    logic [LB_W-1:0]                wr_data;
    logic [KERNEL_SIZE-1:0][PIX_W-1:0] newcol;
    logic [KK-1:0][PIX_W-1:0]       window_reg;
    logic [KK-1:0][PIX_W-1:0]       window_next;

    // lane 0 holds the oldest line
    c2kw_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (shift_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE - 1; i++)
        begin
            newcol[i] = rd_data[i*PIX_W +: PIX_W];
        end
        newcol[KERNEL_SIZE-1] = px;
        // column moves up one line, current pixel enters at the bottom
        for (int i = 0; i < KERNEL_SIZE - 1; i++)
        begin
            wr_data[i*PIX_W +: PIX_W] = newcol[i+1];
        end
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int j = 0; j < KERNEL_SIZE - 1; j++)
            begin
                window_next[i*KERNEL_SIZE + j] = window_reg[i*KERNEL_SIZE + j + 1];
            end
            window_next[i*KERNEL_SIZE + KERNEL_SIZE - 1] = newcol[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift_en)
        begin
            window_reg <= window_next;
        end
    end

    assign window = window_reg;

endmodule

// File: src/c2kw_mac.sv
// coefficient store, product stage and two-level adder for the window sum
// depends on c2kw_pkg
module c2kw_mac
    import c2kw_pkg::*;
#(
    parameter int KERNEL_SIZE = DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int KK         = KERNEL_SIZE * KERNEL_SIZE,
    localparam int RS_W       = PROD_W + $clog2(KERNEL_SIZE),
    localparam int ACC_RAW_W  = PROD_W + $clog2(KK),
    localparam int ACC_W      = (ACC_RAW_W > SUM_W) ? ACC_RAW_W : SUM_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [KK-1:0][PIX_W-1:0]  window,
    input  tag_t                      in_tag,
    input  logic [COL_W-1:0]          in_col,
    input  logic [CIDX_W-1:0]         in_cidx,
    input  logic signed [COEF_W-1:0]  in_cval,
    output tag_t                      res_tag,
    output logic [COL_W-1:0]          res_col,
    output logic signed [SUM_W-1:0]   res_sum
);

    logic signed [COEF_W-1:0] coeff_reg [KK];
    logic signed [PROD_W-1:0] prod_next [KK];
    logic signed [PROD_W-1:0] prod_reg  [KK];
    logic signed [RS_W-1:0]   rs_next   [KERNEL_SIZE];
    logic signed [RS_W-1:0]   rs_reg    [KERNEL_SIZE];
    logic signed [ACC_W-1:0]  acc;
    tag_t                     s3_tag_reg;
    tag_t                     s4_tag_reg;
    logic [COL_W-1:0]         s3_col_reg;
    logic [COL_W-1:0]         s4_col_reg;
    logic                     coeff_wr;

    // coefficient written where products read it, so order is kept
    assign coeff_wr = adv && in_tag.valid && (in_tag.op == OP_COEFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < KK; t++)
            begin
                coeff_reg[t] <= '0;
            end
        end
        else if (coeff_wr)
        begin
            for (int t = 0; t < KK; t++)
            begin
                if (in_cidx == CIDX_W'(t))
                begin
                    coeff_reg[t] <= in_cval;
                end
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < KK; t++)
        begin
            prod_next[t] = $signed({1'b0, window[t]}) * coeff_reg[t];
        end
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            rs_next[i] = '0;
            for (int j = 0; j < KERNEL_SIZE; j++)
            begin
                rs_next[i] = rs_next[i] + RS_W'(prod_reg[i*KERNEL_SIZE + j]);
            end
        end
        acc = '0;
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            acc = acc + ACC_W'(rs_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
        end
        else if (adv)
        begin
            s3_tag_reg <= in_tag;
            s4_tag_reg <= s3_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < KK; t++)
            begin
                prod_reg[t] <= prod_next[t];
            end
            for (int i = 0; i < KERNEL_SIZE; i++)
            begin
                rs_reg[i] <= rs_next[i];
            end
            s3_col_reg <= in_col;
            s4_col_reg <= s3_col_reg;
        end
    end

    assign res_tag = s4_tag_reg;
    assign res_col = s4_col_reg;
    assign res_sum = SUM_W'(acc);

endmodule

// File: src/conv2d_kernel_window.sv
// 2d k by k convolution over a raster pixel stream, with coefficient loads in band
// a pixel passes stage 1, the window, products, row sums and the output register
// throughput: one request per cycle, pixels and coefficient loads alike
// the input stalls only while a result waits and the next one is already complete
// reset: frame 640 x 480, position, window and coefficients zero; the line store
// ram is not cleared, its content is only ever used once written
module conv2d_kernel_window
    import c2kw_pkg::*;
#(
    parameter int KERNEL_SIZE = DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int KK         = KERNEL_SIZE * KERNEL_SIZE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    c2kw_in_if.sink                stream,
    c2kw_out_if.source             result
);

    // widths used for frame-size clamping
    localparam int EW_W  = COL_W + 1;
    localparam int CMP_W = (FW_W > EW_W) ? FW_W : EW_W;

    // configuration
    logic [FW_W-1:0]   fw_reg;
    logic [ROW_W-1:0]  fh_reg;
    logic              restart;

    // frame position
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;

    // position decode of the request at the input
    logic [CMP_W-1:0]  w_ext, w_last, col_ext;
    logic [ROW_W-1:0]  h_eff, h_last, row_cur;
    logic [COL_W-1:0]  col_cur;
    logic              line_end, frame_end, emit;

    // handshake
    logic              adv;
    logic              accept;
    logic              res_done;

    // stage 1: line store read in flight
    tag_t                      s1_tag_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [PIX_W-1:0]          s1_px_reg;
    logic [CIDX_W-1:0]         s1_cidx_reg;
    logic signed [COEF_W-1:0]  s1_cval_reg;

    // stage 2: window holds this pixel's neighborhood
    tag_t                      s2_tag_reg;
    logic [COL_W-1:0]          s2_col_reg;
    logic [CIDX_W-1:0]         s2_cidx_reg;
    logic signed [COEF_W-1:0]  s2_cval_reg;

    logic [KK-1:0][PIX_W-1:0]  window;
    logic                      shift_en;
    tag_t                      res_tag;
    logic [COL_W-1:0]          res_col;
    logic signed [SUM_W-1:0]   res_sum;

    // output register
    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   out_sum_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic [COL_W-1:0]          out_col_reg;
    logic                      out_last_reg;

    // whole pipeline moves together; it only holds when a finished sum
    // would land on an output register that is still waiting
    assign res_done = res_tag.valid && res_tag.emit;
    assign adv      = !(res_done && out_valid_reg && !result.ready);
    assign accept   = stream.valid && adv;
    assign stream.ready = adv;

    // ------------------------------------------------------------------
    // configuration registers; any legal write restarts the frame
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= RST_FRAME_WIDTH;
            fh_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            CFG_FRAME_WIDTH,
            CFG_FRAME_HEIGHT: restart = cfg_wr_en;
            default:          restart = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // position decode: clamp frame size, then clamp the counters so a
    // position past the end wraps like the last pixel of a line or frame
    // ------------------------------------------------------------------
    always_comb
    begin
        w_ext = CMP_W'(fw_reg);
        if (w_ext < CMP_W'(KERNEL_SIZE))
        begin
            w_ext = CMP_W'(KERNEL_SIZE);
        end
        else if (w_ext > CMP_W'(MAX_WIDTH))
        begin
            w_ext = CMP_W'(MAX_WIDTH);
        end
        w_last  = w_ext - CMP_W'(1);
        col_ext = CMP_W'(col_cnt_reg);
        line_end = (col_ext >= w_last);
        col_cur  = line_end ? COL_W'(w_last) : col_cnt_reg;

        h_eff  = (fh_reg < ROW_W'(KERNEL_SIZE)) ? ROW_W'(KERNEL_SIZE) : fh_reg;
        h_last = h_eff - ROW_W'(1);
        row_cur = (row_cnt_reg >= h_last) ? h_last : row_cnt_reg;

        frame_end = line_end && (row_cnt_reg >= h_last);
        emit = (row_cur >= ROW_W'(KERNEL_SIZE - 1)) && (col_cur >= COL_W'(KERNEL_SIZE - 1));

        if (line_end)
        begin
            col_cnt_next = '0;
            row_cnt_next = frame_end ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_cnt_next = col_cur + COL_W'(1);
            row_cnt_next = row_cur;
        end
    end

    // coefficient loads leave the position alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (restart)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept && (stream.operation == OP_PIXEL))
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // stage registers ahead of the multiply-accumulate
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg.valid <= accept;
            s1_tag_reg.op    <= stream.operation;
            s1_tag_reg.emit  <= emit && (stream.operation == OP_PIXEL);
            s1_tag_reg.last  <= frame_end;
            s1_tag_reg.row   <= row_cur - ROW_W'(KERNEL_SIZE / 2);
            s2_tag_reg       <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg  <= col_cur;
            s1_px_reg   <= stream.pixel;
            s1_cidx_reg <= stream.coeff_index;
            s1_cval_reg <= stream.coeff_value;
            s2_col_reg  <= s1_col_reg;
            s2_cidx_reg <= s1_cidx_reg;
            s2_cval_reg <= s1_cval_reg;
        end
    end

    // ------------------------------------------------------------------
    // line store: read the column at accept, write the shifted column when the pixel
    // leaves stage 1; consecutive pixels never share a column (width >= 3),
    // so no forwarding is needed
    // ------------------------------------------------------------------
    assign shift_en = adv && s1_tag_reg.valid && (s1_tag_reg.op == OP_PIXEL);

    c2kw_line_buf #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .rd_addr  (col_cur),
        .shift_en (shift_en),
        .wr_addr  (s1_col_reg),
        .px       (s1_px_reg),
        .window   (window)
    );

    // products in stage 3, row sums in stage 4, final add into the output
    c2kw_mac #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .window  (window),
        .in_tag  (s2_tag_reg),
        .in_col  (s2_col_reg),
        .in_cidx (s2_cidx_reg),
        .in_cval (s2_cval_reg),
        .res_tag (res_tag),
        .res_col (res_col),
        .res_sum (res_sum)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && res_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_done)
        begin
            out_sum_reg  <= res_sum;
            out_row_reg  <= res_tag.row;
            out_col_reg  <= res_col - COL_W'(KERNEL_SIZE / 2);
            out_last_reg <= res_tag.last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.conv_sum      = out_sum_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.last_of_frame = out_last_reg;

endmodule

// File: tb/sv/conv2d_kernel_window_tb.sv
// self-checking testbench for conv2d_kernel_window: directed and random pixel and
// coefficient streams, each window sum checked against a cycle-free predictor
// depends on c2kw_pkg, c2kw_in_if, c2kw_out_if and the conv2d_kernel_window rtl
`timescale 1ns / 100ps

module conv2d_kernel_window_tb;
    import c2kw_pkg::*;

    localparam int KS             = DEF_KERNEL_SIZE;
    localparam int KK             = KS * KS;
    localparam int MAXW           = DEF_MAX_WIDTH;
    localparam int COL_W          = DEF_COL_W;
    localparam int DRAIN_CYCLES   = 12;     // pipeline depth plus margin
    localparam int HOLD_LEN       = 300;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no handshake at all
    localparam int MAX_REPORTS    = 10;
    localparam int WIDE_PIXELS    = 48;     // part of the first line of a clamped wide frame

    // one expected result of the window
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    last;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    c2kw_in_if                   stream_ch ();
    c2kw_out_if #(.COL_W(COL_W)) result_ch ();

    conv2d_kernel_window uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mirror of the block state used to predict window sums
    logic [PIX_W-1:0]         line_mem [KS-1][MAXW];
    logic [PIX_W-1:0]         win_pix [KS][KS];
    logic signed [COEF_W-1:0] kernel_taps [KK];
    logic [FW_W-1:0]          width_reg  = RST_FRAME_WIDTH;
    logic [ROW_W-1:0]         height_reg = RST_FRAME_HEIGHT;
    int unsigned              col_pos = 0;
    int unsigned              row_pos = 0;

    window_result_t pending_sums [$];

    // idling knobs, percent chance of starting an idle burst
    int gap_pct   = 0;
    int stall_pct = 0;
    bit hold_request = 1'b0;

    int error_count   = 0;
    int pixels_sent   = 0;
    int coeffs_loaded = 0;
    int sums_checked  = 0;
    int reg_writes    = 0;

    // one request through the window: updates the mirror, returns 1 when a sum is due
    function automatic bit predict_window_sum(input op_t op, input logic [PIX_W-1:0] px,
                                              input logic [CIDX_W-1:0] idx,
                                              input logic signed [COEF_W-1:0] val,
                                              output window_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [PIX_W-1:0] fresh [KS];
        longint acc;
        bit line_end;
        bit frame_end;
        res = '0;
        // coefficient load: no result, position untouched, bad index dropped
        if (op == OP_COEFF)
        begin
            if (idx < KK)
                kernel_taps[idx] = val;
            return 1'b0;
        end
        // effective frame size after clamping
        w = width_reg;
        if (w < KS)
            w = KS;
        if (w > MAXW)
            w = MAXW;
        h = height_reg;
        if (h < KS)
            h = KS;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        // new window column from the buffered lines plus this pixel
        for (int i = 0; i < KS - 1; i++)
            fresh[i] = line_mem[i][c];
        fresh[KS-1] = px;
        for (int i = 0; i < KS - 2; i++)
            line_mem[i][c] = line_mem[i+1][c];
        line_mem[KS-2][c] = px;
        for (int i = 0; i < KS; i++)
        begin
            for (int j = 0; j < KS - 1; j++)
                win_pix[i][j] = win_pix[i][j+1];
            win_pix[i][KS-1] = fresh[i];
        end
        line_end  = (c >= w - 1);
        frame_end = line_end && (r >= h - 1);
        if (line_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        // border pixels: window not fully inside the frame
        if (r < KS - 1 || c < KS - 1)
            return 1'b0;
        acc = 0;
        for (int i = 0; i < KS; i++)
            for (int j = 0; j < KS; j++)
                acc += longint'(win_pix[i][j]) * longint'(kernel_taps[i*KS + j]);
        res.sum  = acc[SUM_W-1:0];
        res.row  = ROW_W'(r - KS / 2);
        res.col  = COL_W'(c - KS / 2);
        res.last = frame_end;
        return 1'b1;
    endfunction

    // pixel with the extremes weighted in
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // q2.14 coefficient with both extremes and zero weighted in
    function automatic logic [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0:       return COEF_W'(16'h7FFF);
            1:       return COEF_W'(16'h8000);
            2:       return '0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // mostly valid taps, now and then an index the block must drop
    function automatic logic [CIDX_W-1:0] rand_coeff_index();
        if ($urandom_range(0, 9) == 0)
            return CIDX_W'($urandom_range(KK, 2**CIDX_W - 1));
        return CIDX_W'($urandom_range(0, KK - 1));
    endfunction

    // offer one request, wait for its handshake, then record what it should produce
    task automatic send_request(input op_t op, input logic [PIX_W-1:0] px,
                                input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        window_result_t res;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.operation   <= op;
        stream_ch.pixel       <= px;
        stream_ch.coeff_index <= idx;
        stream_ch.coeff_value <= val;
        @(posedge clk);
        while (stream_ch.ready !== 1'b1)
            @(posedge clk);
        if (predict_window_sum(op, px, idx, val, res))
            pending_sums.push_back(res);
        if (op == OP_PIXEL)
            pixels_sent++;
        else if (idx < KK)
            coeffs_loaded++;
    endtask

    // unused coefficient fields carry noise on pixel requests
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        send_request(OP_PIXEL, px, CIDX_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic send_coeff(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        send_request(OP_COEFF, PIX_W'($urandom), idx, val);
    endtask

    task automatic load_random_kernel();
        for (int i = 0; i < KK; i++)
            send_coeff(CIDX_W'(i), rand_coeff());
    endtask

    // stop offering, let every expected sum come out, then cover the pipeline depth
    task automatic drain_results();
        stream_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        // known registers restart the frame, the others are dropped
        if (idx == CFG_FRAME_WIDTH)
        begin
            width_reg = data[FW_W-1:0];
            col_pos   = 0;
            row_pos   = 0;
            reg_writes++;
        end
        else if (idx == CFG_FRAME_HEIGHT)
        begin
            height_reg = data[ROW_W-1:0];
            col_pos    = 0;
            row_pos    = 0;
            reg_writes++;
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        drain_results();
        write_register(CFG_FRAME_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
    endtask

    // smallest frame via clamping, most negative kernel, dropped tap indexes
    task automatic test_kernel_extremes();
        gap_pct   = 0;
        stall_pct = 0;
        // upper data bits beyond the width field are dropped, height 0 clamps up
        set_frame(CFG_DATA_W'(16'hF803), CFG_DATA_W'(16'h0000));
        for (int i = 0; i < KK; i++)
            send_coeff(CIDX_W'(i), COEF_W'(16'h8000));
        // out-of-range taps would change the sum if taken
        send_coeff(CIDX_W'(KK), COEF_W'(16'h7FFF));
        send_coeff(CIDX_W'(2**CIDX_W - 1), COEF_W'(16'h7FFF));
        for (int i = 0; i < KK; i++)
            send_pixel(PIX_W'(8'hFF));
        drain_results();
    endtask

    // writes to indexes past the list must not restart the frame
    task automatic test_ignored_register();
        set_frame(CFG_DATA_W'(5), CFG_DATA_W'(4));
        load_random_kernel();
        repeat (12) send_pixel(rand_pixel());
        drain_results();
        write_register(CFG_IDX_W'(2), CFG_DATA_W'($urandom));
        write_register(CFG_IDX_W'(3), CFG_DATA_W'($urandom));
        repeat (8) send_pixel(rand_pixel());
        drain_results();
    endtask

    // tallest frame setting, a few rows only
    task automatic test_tall_frame();
        gap_pct   = 10;
        stall_pct = 10;
        set_frame(CFG_DATA_W'(3), CFG_DATA_W'(16'hFFFF));
        load_random_kernel();
        repeat (24) send_pixel(rand_pixel());
        drain_results();
    endtask

    // width past the maximum clamps to the full line length; part of the
    // first line gives no window, so any result here is wrong
    task automatic test_wide_frame();
        gap_pct   = 5;
        stall_pct = 5;
        set_frame(CFG_DATA_W'(16'h07FF), CFG_DATA_W'(3));
        load_random_kernel();
        for (int k = 0; k < WIDE_PIXELS; k++)
        begin
            // in-band coefficient changes now and then
            if ($urandom_range(0, 99) < 3)
                send_coeff(rand_coeff_index(), rand_coeff());
            send_pixel(rand_pixel());
        end
        drain_results();
    endtask

    // receiver holds off while requests keep coming, block must fill and stall
    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        set_frame(CFG_DATA_W'(4), CFG_DATA_W'(40));
        load_random_kernel();
        hold_request = 1'b1;
        repeat (120) send_pixel(rand_pixel());
        while (hold_request)
            @(posedge clk);
        drain_results();
    endtask

    // random phases: mostly small frames with random content, random idling
    task automatic test_random_mix(input int target);
        int sent;
        int n;
        int w;
        int h;
        int pick;
        sent = 0;
        while (sent < target)
        begin
            drain_results();
            pick      = $urandom_range(0, 2);
            gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
            pick      = $urandom_range(0, 2);
            stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? $urandom_range(0, 2) :
                (pick == 1) ? $urandom_range(11, 40) : $urandom_range(3, 10);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            // sometimes the frame just carries on from the last phase
            if ($urandom_range(0, 3) != 0)
            begin
                write_register(CFG_FRAME_WIDTH, {5'($urandom), FW_W'(w)});
                write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end
            if ($urandom_range(0, 4) == 0)
                write_register(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1) == 0)
            begin
                load_random_kernel();
                sent += KK;
            end
            n = $urandom_range(8, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_coeff(rand_coeff_index(), rand_coeff());
                send_pixel(rand_pixel());
            end
            sent += n;
        end
        drain_results();
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate();
        gap_pct   = 0;
        stall_pct = 0;
        set_frame(CFG_DATA_W'(8), CFG_DATA_W'(6));
        load_random_kernel();
        repeat (100)
        begin
            if ($urandom_range(0, 99) < 5)
                send_coeff(rand_coeff_index(), rand_coeff());
            send_pixel(rand_pixel());
        end
        drain_results();
    endtask

    // result ready: random stall bursts, or a long hold-off when asked
    initial
    begin : result_sink
        int stall_left;
        int hold_count;
        stall_left = 0;
        hold_count = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                if (hold_count == HOLD_LEN)
                begin
                    hold_count      = 0;
                    hold_request    = 1'b0;
                    result_ch.ready <= 1'b1;
                end
                else
                begin
                    hold_count++;
                    result_ch.ready <= 1'b0;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left      = $urandom_range(1, 16) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // every accepted result against the oldest expected sum
    initial
    begin : sum_checker
        window_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (pending_sums.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result at %0t: sum %0d row %0d col %0d last %0b",
                                 $time, result_ch.conv_sum, result_ch.out_row,
                                 result_ch.out_col, result_ch.last_of_frame);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    sums_checked++;
                    if (result_ch.conv_sum !== want.sum || result_ch.out_row !== want.row ||
                        result_ch.out_col !== want.col ||
                        result_ch.last_of_frame !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("mismatch at %0t (expected/actual):", $time);
                            $display("  sum %0d/%0d row %0d/%0d col %0d/%0d last %0b/%0b",
                                     want.sum, result_ch.conv_sum,
                                     want.row, result_ch.out_row, want.col, result_ch.out_col,
                                     want.last, result_ch.last_of_frame);
                        end
                    end
                end
            end
        end
    end

    // hang detection: too many cycles without any request or result moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : main_sequence
        // known values on every input from time zero
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        stream_ch.valid       <= 1'b0;
        stream_ch.operation   <= OP_PIXEL;
        stream_ch.pixel       <= '0;
        stream_ch.coeff_index <= '0;
        stream_ch.coeff_value <= '0;
        // predictor starts from the reset state, unwritten lines read as zero
        foreach (line_mem[i, j])
            line_mem[i][j] = '0;
        foreach (win_pix[i, j])
            win_pix[i][j] = '0;
        foreach (kernel_taps[i])
            kernel_taps[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_kernel_extremes();
        test_ignored_register();
        test_tall_frame();
        test_wide_frame();
        test_backpressure();
        test_random_mix(150);
        test_full_rate();

        $display("run covered %0d pixels and %0d coefficient loads, %0d window sums checked",
                 pixels_sent, coeffs_loaded, sums_checked);
        $display("%0d frame register writes, widths clamped 3..%0d, heights up to 65535",
                 reg_writes, MAXW);
        if (error_count == 0 && pending_sums.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: conv2d_kernel_window.f
src/c2kw_pkg.sv
src/c2kw_if.sv
src/c2kw_ram.sv
src/c2kw_line_buf.sv
src/c2kw_mac.sv
src/conv2d_kernel_window.sv
tb/sv/conv2d_kernel_window_tb.sv
